FILE: sv/qs_pkg.sv
// ----------------------------------------------------------------------------
// qs_pkg: shared types and constants for the quicksort engine
// Beat payloads of the element and result channels, the default store
// depth and the control group that drives the range stack.
// ----------------------------------------------------------------------------
package qs_pkg;

    // Element width and default store depth
    localparam int DATA_W    = 32;
    localparam int DEPTH_DEF = 64;

    // Input beat: one element of the list
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } qs_elem_t;

    // Output beat: one element of the sorted list
    typedef struct packed {
        logic signed [DATA_W-1:0] value_res;
        logic                     last_res;
        logic                     dropped;
    } qs_result_t;

    // Range stack commands
    typedef struct packed {
        logic push;
        logic pop;
    } qs_stk_ctl_t;

endpackage

FILE: sv/qs_stream_if.sv
// ----------------------------------------------------------------------------
// qs_stream_if: valid/ready channel
// Carries one payload per beat; a beat moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface qs_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

FILE: sv/qs_stack.sv
// ----------------------------------------------------------------------------
// qs_stack: range stack for the quicksort engine
// Holds pending (lo, hi) index ranges in a synchronous memory. A pop
// returns the top entry on top_lo/top_hi in the next cycle.
// ----------------------------------------------------------------------------
module qs_stack #(
    parameter int DEPTH = qs_pkg::DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  qs_pkg::qs_stk_ctl_t      ctl,
    input  logic [$clog2(DEPTH)-1:0] push_lo,
    input  logic [$clog2(DEPTH)-1:0] push_hi,
    output logic                     empty,
    output logic [$clog2(DEPTH)-1:0] top_lo,
    output logic [$clog2(DEPTH)-1:0] top_hi
);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int SP_W  = $clog2(DEPTH + 1);

    logic [2*IDX_W-1:0] mem [DEPTH];
    logic [2*IDX_W-1:0] rd_reg;
    logic [SP_W-1:0]    sp_reg;
    logic [SP_W-1:0]    sp_next;
    logic [SP_W-1:0]    sp_dec;
    logic               room;
    logic               do_push;
    logic               do_pop;

    assign empty   = (sp_reg == '0);
    assign room    = (sp_reg < SP_W'(DEPTH));
    assign sp_dec  = sp_reg - SP_W'(1);
    assign do_push = ctl.push & room;
    assign do_pop  = ctl.pop & ~empty;

    // Advance the stack pointer on push or pop; drop a push onto a full stack
    always_comb
    begin
        sp_next = sp_reg;
        if (do_push)
        begin
            sp_next = sp_reg + SP_W'(1);
        end
        else if (do_pop)
        begin
            sp_next = sp_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
        end
        else
        begin
            sp_reg <= sp_next;
        end
    end

    // Write on push, registered read of the top entry on pop
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[sp_reg[IDX_W-1:0]] <= {push_lo, push_hi};
        end
        if (do_pop)
        begin
            rd_reg <= mem[sp_dec[IDX_W-1:0]];
        end
    end

    assign top_lo = rd_reg[2*IDX_W-1:IDX_W];
    assign top_hi = rd_reg[IDX_W-1:0];

endmodule

FILE: sv/quicksort_engine.sv
// ----------------------------------------------------------------------------
// quicksort_engine: collect, sort and stream signed 32-bit values
// Iterative quicksort with Lomuto partitioning over an element memory.
// ----------------------------------------------------------------------------
// Elements arrive one per beat on elem into a DEPTH-entry memory; elements
// past DEPTH are discarded and flagged on dropped. The beat marked last
// starts the sort, and elem.ready stays low until the final sorted beat has
// been loaded into the output register. Each partition pass pops a range,
// fetches and waits for its pivot, reads and compares each scanned element
// with a second write for each swap, closes with a read of the fill slot,
// swaps the pivot in with two writes and pushes the upper range: the single
// write port of the element memory splits every swap into two writes. Each
// result beat then takes one memory read and one output load. No clearing
// pass follows reset.
// ----------------------------------------------------------------------------
module quicksort_engine #(
    parameter int DEPTH = qs_pkg::DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    qs_stream_if.sink     elem,
    qs_stream_if.source   sorted
);
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = qs_pkg::DATA_W;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_POP,
        ST_PIVOT_RD,
        ST_PIVOT_WT,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SCAN_WR2,
        ST_FIN_WR1,
        ST_FIN_WR2,
        ST_PUSH_HI,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    // Control registers
    state_t                  state_reg,     state_next;
    logic [CNT_W-1:0]        count_reg,     count_next;
    logic                    ovf_reg,       ovf_next;
    logic                    out_valid_reg, out_valid_next;

    // Datapath registers
    logic [IDX_W-1:0]        k_reg,     k_next;
    logic [IDX_W-1:0]        fill_reg,  fill_next;
    logic [IDX_W-1:0]        lo_reg,    lo_next;
    logic [IDX_W-1:0]        hi_reg,    hi_next;
    logic [IDX_W-1:0]        swap_reg,  swap_next;
    logic signed [DATA_W-1:0] pivot_reg, pivot_next;
    logic signed [DATA_W-1:0] tmp_reg,   tmp_next;
    qs_pkg::qs_result_t      out_data_reg, out_data_next;

    // Element memory
    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rd_a_reg;
    logic signed [DATA_W-1:0] rd_b_reg;
    logic                     we;
    logic [IDX_W-1:0]         waddr;
    logic signed [DATA_W-1:0] wdata;
    logic                     re_a;
    logic [IDX_W-1:0]         raddr_a;
    logic                     re_b;
    logic [IDX_W-1:0]         raddr_b;

    // Range stack
    qs_pkg::qs_stk_ctl_t      stk_ctl;
    logic [IDX_W-1:0]         push_lo;
    logic [IDX_W-1:0]         push_hi;
    logic                     stk_empty;
    logic [IDX_W-1:0]         stk_lo;
    logic [IDX_W-1:0]         stk_hi;

    // Helpers
    logic                     room;
    logic [CNT_W-1:0]         n_load;
    logic [CNT_W-1:0]         n_dec;
    logic [CNT_W-1:0]         cnt_dec;
    logic [IDX_W:0]           fill_x;
    logic [IDX_W:0]           lo_x;
    logic [IDX_W:0]           hi_x;
    logic                     emit_last;

    assign room      = (count_reg < CNT_W'(DEPTH));
    assign n_load    = room ? (count_reg + CNT_W'(1)) : count_reg;
    assign n_dec     = n_load - CNT_W'(1);
    assign cnt_dec   = count_reg - CNT_W'(1);
    assign fill_x    = {1'b0, fill_reg};
    assign lo_x      = {1'b0, lo_reg};
    assign hi_x      = {1'b0, hi_reg};
    assign emit_last = (k_reg == cnt_dec[IDX_W-1:0]);

    qs_stack #(
        .DEPTH (DEPTH)
    ) u_qs_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (stk_ctl),
        .push_lo (push_lo),
        .push_hi (push_hi),
        .empty   (stk_empty),
        .top_lo  (stk_lo),
        .top_hi  (stk_hi)
    );

    // Sequence load, partition passes and emission
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        k_next         = k_reg;
        fill_next      = fill_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        swap_next      = swap_reg;
        pivot_next     = pivot_reg;
        tmp_next       = tmp_reg;
        out_data_next  = out_data_reg;
        we             = 1'b0;
        waddr          = '0;
        wdata          = '0;
        re_a           = 1'b0;
        raddr_a        = '0;
        re_b           = 1'b0;
        raddr_b        = '0;
        stk_ctl        = '0;
        push_lo        = '0;
        push_hi        = '0;
        elem.ready     = 1'b0;

        // Drop the output beat once taken
        if (out_valid_reg && sorted.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                elem.ready = 1'b1;
                if (elem.valid)
                begin
                    if (room)
                    begin
                        we         = 1'b1;
                        waddr      = count_reg[IDX_W-1:0];
                        wdata      = elem.data.value;
                        count_next = n_load;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (elem.data.last)
                    begin
                        priority if (n_load >= CNT_W'(2))
                        begin
                            stk_ctl.push = 1'b1;
                            push_lo      = '0;
                            push_hi      = n_dec[IDX_W-1:0];
                            state_next   = ST_POP;
                        end
                        else if (n_load == CNT_W'(1))
                        begin
                            k_next     = '0;
                            state_next = ST_EMIT_RD;
                        end
                        else
                        begin
                            ovf_next = 1'b0;
                        end
                    end
                end
            end

            ST_POP:
            begin
                if (stk_empty)
                begin
                    k_next     = '0;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    stk_ctl.pop = 1'b1;
                    state_next  = ST_PIVOT_RD;
                end
            end

            // Take the popped range and fetch its pivot
            ST_PIVOT_RD:
            begin
                lo_next    = stk_lo;
                hi_next    = stk_hi;
                k_next     = stk_lo;
                fill_next  = stk_lo;
                re_a       = 1'b1;
                raddr_a    = stk_hi;
                state_next = ST_PIVOT_WT;
            end

            ST_PIVOT_WT:
            begin
                pivot_next = rd_a_reg;
                state_next = ST_SCAN_RD;
            end

            // Fetch the scanned element and the fill slot, or only the fill slot at the end
            ST_SCAN_RD:
            begin
                re_a    = 1'b1;
                if (k_reg == hi_reg)
                begin
                    raddr_a    = fill_reg;
                    state_next = ST_FIN_WR1;
                end
                else
                begin
                    raddr_a    = k_reg;
                    re_b       = 1'b1;
                    raddr_b    = fill_reg;
                    state_next = ST_SCAN_CMP;
                end
            end

            // Compare against the pivot; start the swap when needed
            ST_SCAN_CMP:
            begin
                k_next     = k_reg + IDX_W'(1);
                state_next = ST_SCAN_RD;
                if (rd_a_reg <= pivot_reg)
                begin
                    fill_next = fill_reg + IDX_W'(1);
                    if (fill_reg != k_reg)
                    begin
                        we         = 1'b1;
                        waddr      = fill_reg;
                        wdata      = rd_a_reg;
                        tmp_next   = rd_b_reg;
                        swap_next  = k_reg;
                        state_next = ST_SCAN_WR2;
                    end
                end
            end

            ST_SCAN_WR2:
            begin
                we         = 1'b1;
                waddr      = swap_reg;
                wdata      = tmp_reg;
                state_next = ST_SCAN_RD;
            end

            // Swap the pivot into its final slot and push the lower subrange
            ST_FIN_WR1:
            begin
                we         = 1'b1;
                waddr      = hi_reg;
                wdata      = rd_a_reg;
                state_next = ST_FIN_WR2;
            end

            ST_FIN_WR2:
            begin
                we    = 1'b1;
                waddr = fill_reg;
                wdata = pivot_reg;
                if (fill_x > (lo_x + (IDX_W + 1)'(1)))
                begin
                    stk_ctl.push = 1'b1;
                    push_lo      = lo_reg;
                    push_hi      = fill_reg - IDX_W'(1);
                end
                state_next = ST_PUSH_HI;
            end

            ST_PUSH_HI:
            begin
                if ((fill_x + (IDX_W + 1)'(1)) < hi_x)
                begin
                    stk_ctl.push = 1'b1;
                    push_lo      = fill_reg + IDX_W'(1);
                    push_hi      = hi_reg;
                end
                state_next = ST_POP;
            end

            ST_EMIT_RD:
            begin
                re_a       = 1'b1;
                raddr_a    = k_reg;
                state_next = ST_EMIT_LD;
            end

            // Load the output register once it is free
            ST_EMIT_LD:
            begin
                if (!out_valid_reg || sorted.ready)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.value_res = rd_a_reg;
                    out_data_next.last_res  = emit_last;
                    out_data_next.dropped   = ovf_reg;
                    if (emit_last)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold datapath registers
    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        fill_reg     <= fill_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        swap_reg     <= swap_next;
        pivot_reg    <= pivot_next;
        tmp_reg      <= tmp_next;
        out_data_reg <= out_data_next;
    end

    // Element memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re_a)
        begin
            rd_a_reg <= mem[raddr_a];
        end
        if (re_b)
        begin
            rd_b_reg <= mem[raddr_b];
        end
    end

    assign sorted.valid = out_valid_reg;
    assign sorted.data  = out_data_reg;

endmodule

FILE: sv/qs_checker.sv
// ----------------------------------------------------------------------------
// qs_checker: port-level checks for the quicksort engine
// Watches both channels and checks ordering, run flags and busy behavior.
// ----------------------------------------------------------------------------
module qs_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       elem_valid,
    input logic                       elem_ready,
    input logic                       elem_last,
    input logic                       sorted_valid,
    input logic                       sorted_ready,
    input logic signed [qs_pkg::DATA_W-1:0] sorted_value,
    input logic                       sorted_last,
    input logic                       sorted_dropped
);
    logic                             take;
    logic                             in_run_reg;
    logic signed [qs_pkg::DATA_W-1:0] prev_value_reg;
    logic                             prev_dropped_reg;

    assign take = sorted_valid & sorted_ready;

    // Track the previous result beat of the current run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_run_reg       <= 1'b0;
            prev_value_reg   <= '0;
            prev_dropped_reg <= 1'b0;
        end
        else if (take)
        begin
            in_run_reg       <= ~sorted_last;
            prev_value_reg   <= sorted_value;
            prev_dropped_reg <= sorted_dropped;
        end
    end

    // A stalled result beat holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        sorted_valid && !sorted_ready |=> sorted_valid && $stable(sorted_value)
            && $stable(sorted_last) && $stable(sorted_dropped))
        else $error("result beat changed while stalled");

    // Results of one run come out in ascending order
    a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
        take && in_run_reg |-> prev_value_reg <= sorted_value)
        else $error("sorted results out of order");

    // The dropped flag is the same on every beat of a run
    a_dropped_const: assert property (@(posedge clk) disable iff (!rst_n)
        take && in_run_reg |-> sorted_dropped == prev_dropped_reg)
        else $error("dropped flag changed within a run");

    // The closing element starts the sort, so intake stalls next cycle
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        elem_valid && elem_ready && elem_last |=> !elem_ready)
        else $error("element accepted while sorting");

endmodule

bind quicksort_engine qs_checker u_qs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .elem_valid     (elem.valid),
    .elem_ready     (elem.ready),
    .elem_last      (elem.data.last),
    .sorted_valid   (sorted.valid),
    .sorted_ready   (sorted.ready),
    .sorted_value   (sorted.data.value_res),
    .sorted_last    (sorted.data.last_res),
    .sorted_dropped (sorted.data.dropped)
);

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the quicksort engine
// Streams lists of signed values into the engine with bursty valid and a
// stalling result sink, sorts each list in a local Lomuto quicksort and
// checks every sorted beat field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
    localparam int DATA_W       = qs_pkg::DATA_W;
    localparam int DEPTH_DEF    = qs_pkg::DEPTH_DEF;
    localparam int CLK_HALF     = 4;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int TAIL_CYCLES  = 200;
    localparam int RAND_ITEMS   = 140;

    // One pending element beat; hold makes the sender wait for an idle engine
    typedef struct {
        qs_pkg::qs_elem_t beat;
        bit               hold;
    } elem_item_t;

    logic clk;
    logic rst_n;

    qs_stream_if #(.payload_t(qs_pkg::qs_elem_t))   elem_if ();
    qs_stream_if #(.payload_t(qs_pkg::qs_result_t)) sorted_if ();

    quicksort_engine #(.DEPTH(DEPTH_DEF)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .elem   (elem_if),
        .sorted (sorted_if)
    );

    elem_item_t               elem_beats_q [$];
    qs_pkg::qs_result_t       sorted_vals_q [$];
    logic signed [DATA_W-1:0] store_m [DEPTH_DEF];
    int                       fill_cnt;
    bit                       drop_m;
    int                       err_cnt;
    int                       cycle_cnt;
    int                       burst_left;
    int                       gap_left;
    int                       stall_mode;
    int                       stall_phase;

    // Print one mismatch line and count it
    task automatic report_mismatch(string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    // Queue one element beat for the sender
    task automatic add_elem(logic [DATA_W-1:0] v, bit is_last, bit hold);
        elem_item_t it;
        it.beat.value = v;
        it.beat.last  = is_last;
        it.hold       = hold;
        elem_beats_q.push_back(it);
    endtask

    // Absorb an accepted element; on the last one sort and queue the results
    task automatic predict_sorted(qs_pkg::qs_elem_t b);
        int                       lo_stk [DEPTH_DEF];
        int                       hi_stk [DEPTH_DEF];
        int                       sp;
        int                       lo;
        int                       hi;
        int                       fill;
        int                       n;
        logic signed [DATA_W-1:0] pivot;
        logic signed [DATA_W-1:0] tmp;
        qs_pkg::qs_result_t       r;
        if (fill_cnt < DEPTH_DEF) begin
            store_m[fill_cnt] = b.value;
            fill_cnt++;
        end
        else begin
            drop_m = 1'b1;
        end
        if (b.last) begin
            n  = fill_cnt;
            sp = 0;
            if (n >= 2) begin
                lo_stk[0] = 0;
                hi_stk[0] = n - 1;
                sp = 1;
            end
            // Lomuto partition around the last element of each popped range
            while (sp > 0) begin
                sp--;
                lo    = lo_stk[sp];
                hi    = hi_stk[sp];
                pivot = store_m[hi];
                fill  = lo;
                for (int k = lo; k < hi; k++) begin
                    if (store_m[k] <= pivot) begin
                        tmp           = store_m[fill];
                        store_m[fill] = store_m[k];
                        store_m[k]    = tmp;
                        fill++;
                    end
                end
                tmp           = store_m[fill];
                store_m[fill] = store_m[hi];
                store_m[hi]   = tmp;
                // Push only subranges of two or more elements
                if (fill > lo + 1 && sp < DEPTH_DEF) begin
                    lo_stk[sp] = lo;
                    hi_stk[sp] = fill - 1;
                    sp++;
                end
                if (fill + 1 < hi && sp < DEPTH_DEF) begin
                    lo_stk[sp] = fill + 1;
                    hi_stk[sp] = hi;
                    sp++;
                end
            end
            for (int k = 0; k < n; k++) begin
                r.value_res = store_m[k];
                r.last_res  = (k == n - 1);
                r.dropped   = drop_m;
                sorted_vals_q.push_back(r);
            end
            fill_cnt = 0;
            drop_m   = 1'b0;
        end
    endtask

    // Pick a value for a list of the given flavor
    function automatic logic [DATA_W-1:0] pick_value(int kind, logic [DATA_W-1:0] base, int idx);
        logic [DATA_W-1:0] v;
        case (kind)
            3:       v = DATA_W'($signed($urandom_range(0, 8)) - 4);
            4:       v = base + DATA_W'(idx);
            5:       v = base - DATA_W'(idx);
            default: v = $urandom;
        endcase
        // Sprinkle in the extremes
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0:       v = 32'h8000_0000;
                1:       v = 32'h7fff_ffff;
                2:       v = '0;
                default: v = '1;
            endcase
        end
        return v;
    endfunction

    // Clock
    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Known levels on every engine input from time zero
    initial begin
        elem_if.valid  = 1'b0;
        elem_if.data   = '0;
        sorted_if.ready = 1'b0;
    end

    // Sender: bursts of beats with random gaps, valid held until accepted
    always @(posedge clk) begin
        elem_item_t nxt;
        if (!rst_n) begin
            elem_if.valid <= 1'b0;
            elem_if.data  <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else begin
            if (elem_if.valid && elem_if.ready) begin
                predict_sorted(elem_if.data);
            end
            if (elem_if.valid && !elem_if.ready) begin
                // hold the current beat
            end
            else if (gap_left > 0) begin
                gap_left--;
                elem_if.valid <= 1'b0;
            end
            else if (elem_beats_q.size() != 0 &&
                     !(elem_beats_q[0].hold && sorted_vals_q.size() != 0)) begin
                nxt = elem_beats_q.pop_front();
                elem_if.valid <= 1'b1;
                elem_if.data  <= nxt.beat;
                if (burst_left > 0) begin
                    burst_left--;
                end
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                end
            end
            else begin
                elem_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: a randomly chosen stall pattern, redrawn when stall_phase wraps to zero
    always @(posedge clk) begin
        if (!rst_n) begin
            sorted_if.ready <= 1'b0;
            stall_mode  = 0;
            stall_phase = 0;
        end
        else begin
            if (stall_phase == 0) begin
                stall_mode = $urandom_range(0, 3);
            end
            stall_phase = (stall_phase + 1) % 50;
            case (stall_mode)
                0:       sorted_if.ready <= 1'b1;
                1:       sorted_if.ready <= ($urandom_range(0, 3) != 0);
                2:       sorted_if.ready <= ($urandom_range(0, 3) == 0);
                default: sorted_if.ready <= stall_phase[0];
            endcase
        end
    end

    // Monitor: compare each sorted beat with the oldest expectation
    always @(posedge clk) begin
        qs_pkg::qs_result_t got;
        qs_pkg::qs_result_t want;
        if (rst_n && sorted_if.valid && sorted_if.ready) begin
            got = sorted_if.data;
            if (sorted_vals_q.size() == 0) begin
                report_mismatch($sformatf("unexpected beat value_res=%0d", got.value_res));
            end
            else begin
                want = sorted_vals_q.pop_front();
                if (got.value_res !== want.value_res)
                    report_mismatch($sformatf("value_res got %0d want %0d",
                                              got.value_res, want.value_res));
                if (got.last_res !== want.last_res)
                    report_mismatch($sformatf("last_res got %b want %b",
                                              got.last_res, want.last_res));
                if (got.dropped !== want.dropped)
                    report_mismatch($sformatf("dropped got %b want %b",
                                              got.dropped, want.dropped));
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin
        int                rand_cnt;
        int                run_len;
        int                kind;
        bit                hold;
        bit                first;
        logic [DATA_W-1:0] base;
        err_cnt   = 0;
        cycle_cnt = 0;
        fill_cnt  = 0;
        drop_m    = 1'b0;
        rst_n     = 1'b0;

        // Directed: single elements at both extremes, waiting for idle each time
        add_elem(32'h8000_0000, 1'b1, 1'b1);
        add_elem(32'h7fff_ffff, 1'b1, 1'b1);
        // Extremes mixed with duplicates
        add_elem(32'h0000_0000, 1'b0, 1'b0);
        add_elem(32'hffff_ffff, 1'b0, 1'b0);
        add_elem(32'h7fff_ffff, 1'b0, 1'b0);
        add_elem(32'h8000_0000, 1'b0, 1'b0);
        add_elem(32'h0000_0001, 1'b0, 1'b0);
        add_elem(32'hffff_ffff, 1'b0, 1'b0);
        add_elem(32'h0000_0000, 1'b1, 1'b0);
        // Descending list
        add_elem(32'd40, 1'b0, 1'b0);
        add_elem(32'd30, 1'b0, 1'b0);
        add_elem(32'd20, 1'b0, 1'b0);
        add_elem(32'd10, 1'b1, 1'b0);
        // All equal
        add_elem(32'hffff_fff9, 1'b0, 1'b1);
        add_elem(32'hffff_fff9, 1'b0, 1'b0);
        add_elem(32'hffff_fff9, 1'b1, 1'b0);
        // Two elements already in order
        add_elem(32'd1, 1'b0, 1'b0);
        add_elem(32'd2, 1'b1, 1'b0);

        // Random lists: one overflowing list first, then mostly short ones
        rand_cnt = 0;
        first    = 1'b1;
        while (rand_cnt < RAND_ITEMS) begin
            if (first)
                run_len = DEPTH_DEF + 3;
            else if ($urandom_range(0, 9) == 0)
                run_len = $urandom_range(DEPTH_DEF - 4, DEPTH_DEF + 6);
            else
                run_len = $urandom_range(1, 12);
            kind = $urandom_range(0, 5);
            hold = ($urandom_range(0, 3) == 0);
            base = $urandom;
            for (int k = 0; k < run_len; k++) begin
                add_elem(pick_value(kind, base, k), k == run_len - 1, hold && k == 0);
            end
            rand_cnt += run_len;
            first = 1'b0;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: all beats sent, all results seen, then a quiet tail
        while (elem_beats_q.size() != 0 || elem_if.valid || sorted_vals_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_cnt == 0) begin
            $display("status: pass");
        end
        else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/qs_pkg.sv
sv/qs_stream_if.sv
sv/qs_stack.sv
sv/quicksort_engine.sv
sv/qs_checker.sv
bench/tb_top.sv
